// ===== src/sld_pkg.sv =====
// Shared types and constants for the sync-word length-prefixed deframer.
package sld_pkg;

  localparam logic [7:0] SYNC_FIRST_RESET  = 8'h55;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'hDA;

  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  typedef enum logic [1:0] {
    PHASE_HUNT   = 2'd0,
    PHASE_FIRST  = 2'd1,
    PHASE_LENGTH = 2'd2,
    PHASE_DATA   = 2'd3
  } phase_t;

  typedef struct packed {
    logic       empty_frame;
    logic       last_of_frame;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
  } result_t;

endpackage

// ===== src/sld_parser.sv =====
// Sync hunt, length capture, payload tagging: one byte per cycle unless out_busy.
module sld_parser
  import sld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic [7:0] data_byte,
  input  logic [7:0] sync_first,
  input  logic [7:0] sync_second,
  input  logic       out_busy,
  output logic       advance,
  output logic       res_valid,
  output result_t    res
);

  phase_t     phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] current_length, current_length_next;

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    current_length_next = current_length;
    res_valid           = 1'b0;
    res                 = '0;
    unique case (phase)
      PHASE_HUNT: begin
        if (data_byte == sync_first) begin
          phase_next = PHASE_FIRST;
        end
      end
      PHASE_FIRST: begin
        if (data_byte == sync_second) begin
          phase_next = PHASE_LENGTH;
        end else if (data_byte == sync_first) begin
          phase_next = PHASE_FIRST;
        end else begin
          phase_next = PHASE_HUNT;
        end
      end
      PHASE_LENGTH: begin
        current_length_next = data_byte;
        if (data_byte == 8'd0) begin
          bytes_left_next   = 8'd0;
          phase_next        = PHASE_HUNT;
          res_valid         = 1'b1;
          res.last_of_frame = 1'b1;
          res.empty_frame   = 1'b1;
        end else begin
          bytes_left_next = data_byte;
          phase_next      = PHASE_DATA;
        end
      end
      PHASE_DATA: begin
        res_valid          = 1'b1;
        res.payload_byte   = data_byte;
        res.frame_length   = current_length;
        res.last_of_frame  = (bytes_left <= 8'd1);
        if (bytes_left <= 8'd1) begin
          bytes_left_next = 8'd0;
          phase_next      = PHASE_HUNT;
        end else begin
          bytes_left_next = bytes_left - 8'd1;
        end
      end
      default: begin
        phase_next = PHASE_HUNT;
      end
    endcase
  end

  // drop non-result bytes at once; hold result bytes while the output is busy
  assign advance = byte_valid && !(res_valid && out_busy);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PHASE_HUNT;
      bytes_left     <= 8'd0;
      current_length <= 8'd0;
    end else if (advance) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      current_length <= current_length_next;
    end
  end

endmodule

// ===== src/sld_out_reg.sv =====
// Output register holding one result transaction until the downstream side takes it.
module sld_out_reg
  import sld_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  input  logic    tready,
  output logic    tvalid,
  output logic    busy,
  output result_t held
);

  logic tvalid_next;

  always_comb begin
    tvalid_next = tvalid;
    if (load) begin
      tvalid_next = 1'b1;
    end else if (tready) begin
      tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else begin
      tvalid <= tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign busy = tvalid && !tready;

endmodule

// ===== src/sync_length_deframer.sv =====
// Top level of the sync-word length-prefixed stream deframer.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata[7:0] data_byte
//  m_axis    out        tdata[7:0] payload_byte, tdata[15:8] frame_length,
//                       tlast last_of_frame, tuser empty_frame
//  cfg       in         cfg_index 0 sync_first, 1 sync_second; cfg_data byte
//
// One byte per cycle is sustained while the result register is not full; each result
// passes through the input register and then the result register.
// rst is synchronous: hunt phase, counters cleared, sync bytes 0x55 / 0xDA.
// A full, unread result register stalls only bytes that produce a result; other bytes
// are consumed and dropped while the result waits.
module sync_length_deframer
  import sld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] frame_length
  output logic        m_axis_tlast,   // last_of_frame
  output logic        m_axis_tuser,   // empty_frame
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] sync_first, sync_second;
  logic       in_valid, in_valid_next;
  logic [7:0] in_byte;
  logic       advance, res_valid, out_busy;
  result_t    res, held;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RESET;
      sync_second <= SYNC_SECOND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !in_valid || advance;

  always_comb begin
    in_valid_next = in_valid;
    if (s_axis_tready) begin
      in_valid_next = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  sld_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (in_valid),
    .data_byte   (in_byte),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .out_busy    (out_busy),
    .advance     (advance),
    .res_valid   (res_valid),
    .res         (res)
  );

  sld_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && res_valid),
    .res    (res),
    .tready (m_axis_tready),
    .tvalid (m_axis_tvalid),
    .busy   (out_busy),
    .held   (held)
  );

  assign m_axis_tdata = {held.frame_length, held.payload_byte};
  assign m_axis_tlast = held.last_of_frame;
  assign m_axis_tuser = held.empty_frame;

endmodule
